// ===== rtl/ita_pkg.sv =====
// Shared widths, codes and character helpers for the integer to ASCII formatter.
package ita_pkg;

  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned KindWidth   = 3;
  localparam int unsigned CharWidth   = 8;
  localparam int unsigned BinWidth    = 32;
  localparam int unsigned BcdDigits   = 10;
  localparam int unsigned BcdWidth    = 4 * BcdDigits;
  localparam int unsigned NibCount    = ValueWidth / 4;
  localparam int unsigned CntWidth    = $clog2(NibCount);
  localparam int unsigned StepWidth   = $clog2(BinWidth);
  localparam int unsigned PfxIdxWidth = 3;

  typedef enum logic [KindWidth-1:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_HEXL = 3'd2,
    KIND_HEXU = 3'd3,
    KIND_PTR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PFX_NONE  = 2'd0,
    PFX_MINUS = 2'd1,
    PFX_HEX   = 2'd2,
    PFX_NIL   = 2'd3
  } pfx_e;

  localparam logic [CharWidth-1:0] ChZero  = 8'h30;
  localparam logic [CharWidth-1:0] ChUpperA = 8'h41;
  localparam logic [CharWidth-1:0] ChLowerA = 8'h61;
  localparam logic [CharWidth-1:0] ChMinus = 8'h2d;
  localparam logic [CharWidth-1:0] ChX     = 8'h78;
  localparam logic [CharWidth-1:0] ChOpen  = 8'h28;
  localparam logic [CharWidth-1:0] ChN     = 8'h6e;
  localparam logic [CharWidth-1:0] ChI     = 8'h69;
  localparam logic [CharWidth-1:0] ChL     = 8'h6c;
  localparam logic [CharWidth-1:0] ChClose = 8'h29;

  function automatic logic [CharWidth-1:0] digit_char(logic [3:0] nib, logic upper);
    logic [CharWidth-1:0] ext;
    ext = {4'b0000, nib};
    if (nib < 4'd10) begin
      return ChZero + ext;
    end
    return (upper ? ChUpperA : ChLowerA) + ext - 8'd10;
  endfunction

  function automatic logic [PfxIdxWidth-1:0] pfx_last_idx(pfx_e p);
    case (p)
      PFX_HEX: return 3'd1;
      PFX_NIL: return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [CharWidth-1:0] pfx_char(pfx_e p, logic [PfxIdxWidth-1:0] idx);
    logic [CharWidth-1:0] ch;
    ch = ChMinus;
    case (p)
      PFX_HEX: ch = (idx == 3'd0) ? ChZero : ChX;
      PFX_NIL: begin
        case (idx)
          3'd0:    ch = ChOpen;
          3'd1:    ch = ChN;
          3'd2:    ch = ChI;
          3'd3:    ch = ChL;
          default: ch = ChClose;
        endcase
      end
      default: ch = ChMinus;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/ita_bcd.sv =====
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
module ita_bcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ita_pkg::BinWidth-1:0]  bin_i,
  output logic                          done_o,
  output logic [ita_pkg::BcdWidth-1:0]  bcd_o
);
  import ita_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [StepWidth-1:0] step_q;
  logic [BinWidth-1:0]  bin_q;
  logic [BcdWidth-1:0]  bcd_q;
  logic [BcdWidth-1:0]  adj;
  logic                 last_step;

  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
    end
  end

  assign last_step = (step_q == StepWidth'(BinWidth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= bin_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[BinWidth-2:0], 1'b0};
      bcd_q <= {adj[BcdWidth-2:0], bin_q[BinWidth-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Top level: formats one integer word into a stream of ASCII character words.
//
//  channel  | dir | tdata              | side band
//  s_axis   | in  | [63:0] value       | tuser [2:0] kind
//  m_axis   | out | [7:0] character    | tlast marks the final character
//
// Decimal kinds: an accept step, 32 BCD shift steps and a hand-off step, then strip
// steps for leading zero nibbles and character steps, a minus sign first if negative.
// Hex kinds skip the BCD unit; a pointer adds a "0x" prefix, a null pointer "(nil)".
// Reset clears the sequencer and output valid; input is taken only when idle.
// A stalled output holds its character; the sequencer waits for a free slot.
module integer_to_ascii_formatter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ita_pkg::ValueWidth-1:0]  s_axis_tdata,  // [63:0] value
  input  logic [ita_pkg::KindWidth-1:0]   s_axis_tuser,  // [2:0] kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ita_pkg::CharWidth-1:0]   m_axis_tdata,  // [7:0] character
  output logic                            m_axis_tlast
);
  import ita_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_STRIP = 5'b00100,
    S_PRE   = 5'b01000,
    S_DIGIT = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  pfx_e                   pfx_q, pfx_d;
  logic [PfxIdxWidth-1:0] pidx_q, pidx_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [ValueWidth-1:0]  dig_q, dig_d;
  logic                   upper_q, upper_d;
  logic                   ovalid_q, ovalid_d;
  logic [CharWidth-1:0]   ochar_q, ochar_d;
  logic                   olast_q, olast_d;

  logic                   accept;
  logic                   slot_free;
  logic                   bcd_start;
  logic                   bcd_done;
  logic [BinWidth-1:0]    low;
  logic [BinWidth-1:0]    mag;
  logic [BcdWidth-1:0]    bcd;
  logic [3:0]             top_nib;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !ovalid_q || m_axis_tready;
  assign low           = s_axis_tdata[BinWidth-1:0];
  assign top_nib       = dig_q[ValueWidth-1 -: 4];

  always_comb begin
    mag = low;
    if (kind_e'(s_axis_tuser) == KIND_SDEC && low[BinWidth-1]) begin
      mag = ~low + 1'b1;
    end
  end

  ita_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .bin_i   (mag),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  always_comb begin
    state_d   = state_q;
    pfx_d     = pfx_q;
    pidx_d    = pidx_q;
    cnt_d     = cnt_q;
    dig_d     = dig_q;
    upper_d   = upper_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    ochar_d   = ochar_q;
    olast_d   = olast_q;
    bcd_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          pidx_d  = '0;
          cnt_d   = CntWidth'(NibCount - 1);
          dig_d   = s_axis_tdata;
          upper_d = 1'b0;
          pfx_d   = PFX_NONE;
          case (kind_e'(s_axis_tuser))
            KIND_SDEC, KIND_UDEC: begin
              bcd_start = 1'b1;
              if (kind_e'(s_axis_tuser) == KIND_SDEC && low[BinWidth-1]) begin
                pfx_d = PFX_MINUS;
              end
              state_d = S_CONV;
            end
            KIND_HEXL: state_d = S_STRIP;
            KIND_HEXU: begin
              upper_d = 1'b1;
              state_d = S_STRIP;
            end
            KIND_PTR: begin
              if (s_axis_tdata == '0) begin
                pfx_d   = PFX_NIL;
                state_d = S_PRE;
              end else begin
                pfx_d   = PFX_HEX;
                state_d = S_STRIP;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          dig_d   = {{(ValueWidth - BcdWidth){1'b0}}, bcd};
          state_d = S_STRIP;
        end
      end
      S_STRIP: begin
        if (cnt_q != '0 && top_nib == 4'd0) begin
          dig_d = {dig_q[ValueWidth-5:0], 4'd0};
          cnt_d = cnt_q - 1'b1;
        end else if (pfx_q == PFX_NONE) begin
          state_d = S_DIGIT;
        end else begin
          state_d = S_PRE;
        end
      end
      S_PRE: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ochar_d  = pfx_char(pfx_q, pidx_q);
          olast_d  = 1'b0;
          pidx_d   = pidx_q + 1'b1;
          if (pidx_q == pfx_last_idx(pfx_q)) begin
            if (pfx_q == PFX_NIL) begin
              olast_d = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_DIGIT;
            end
          end
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ochar_d  = digit_char(top_nib, upper_q);
          olast_d  = (cnt_q == '0);
          dig_d    = {dig_q[ValueWidth-5:0], 4'd0};
          cnt_d    = cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pfx_q   <= pfx_d;
    pidx_q  <= pidx_d;
    cnt_q   <= cnt_d;
    dig_q   <= dig_d;
    upper_q <= upper_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = ochar_q;
  assign m_axis_tlast  = olast_q;

endmodule
